>>> hdl/x64_instruction_encoder_assert.svh
// assertion macros used by the port-level checker of the instruction encoder
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef X64_INSTRUCTION_ENCODER_ASSERT_SVH
`define X64_INSTRUCTION_ENCODER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define X64E_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define X64E_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/x64e_pkg.sv
// types, codes and opcode constants of the x86-64 instruction encoder
// no dependencies; imported by every module of the encoder
package x64e_pkg;

    // request forms
    localparam logic [4:0] FN_MOV_RR     = 5'd0;
    localparam logic [4:0] FN_MOV_IMM    = 5'd1;
    localparam logic [4:0] FN_MOVZX_MEM  = 5'd2;
    localparam logic [4:0] FN_MOVZX_R8   = 5'd3;
    localparam logic [4:0] FN_JMP_R      = 5'd4;
    localparam logic [4:0] FN_CALL_R     = 5'd5;
    localparam logic [4:0] FN_RET        = 5'd6;
    localparam logic [4:0] FN_PUSH       = 5'd7;
    localparam logic [4:0] FN_POP        = 5'd8;
    localparam logic [4:0] FN_ADD_RR     = 5'd9;
    localparam logic [4:0] FN_ADC_RR     = 5'd10;
    localparam logic [4:0] FN_SUB_RR     = 5'd11;
    localparam logic [4:0] FN_TEST_RR    = 5'd12;
    localparam logic [4:0] FN_CMP_RR     = 5'd13;
    localparam logic [4:0] FN_AND_RR     = 5'd14;
    localparam logic [4:0] FN_OR_RR      = 5'd15;
    localparam logic [4:0] FN_XOR_RR     = 5'd16;
    localparam logic [4:0] FN_ADD_IMM    = 5'd17;
    localparam logic [4:0] FN_ADC_IMM    = 5'd18;
    localparam logic [4:0] FN_SUB_IMM    = 5'd19;
    localparam logic [4:0] FN_BRANCH_S   = 5'd20;
    localparam logic [4:0] FN_BRANCH_N   = 5'd21;

    // branch condition codes above the sixteen flag conditions
    localparam logic [4:0] COND_JMP      = 5'd16;
    localparam logic [4:0] COND_CALL     = 5'd17;

    // mov imm length requests
    localparam logic [3:0] LEN_SHORTEST  = 4'd0;
    localparam logic [3:0] LEN_SEXT32    = 4'd7;

    // special r/m register codes
    localparam logic [2:0] RM_RSP        = 3'd4;
    localparam logic [2:0] RM_RBP        = 3'd5;

    // opcode and prefix bytes
    localparam logic [7:0] REX_W         = 8'h48;
    localparam logic [7:0] REX_WB        = 8'h49;
    localparam logic [7:0] REX_B         = 8'h41;
    localparam logic [7:0] MODRM_REG     = 8'hc0;
    localparam logic [7:0] OP_MOV_RM     = 8'h8b;
    localparam logic [7:0] OP_MOV_IMM    = 8'hb8;
    localparam logic [7:0] OP_MOV_IMM32  = 8'hc7;
    localparam logic [7:0] OP_XOR_RM     = 8'h33;
    localparam logic [7:0] OP_ESC        = 8'h0f;
    localparam logic [7:0] OP_MOVZX      = 8'hb6;
    localparam logic [7:0] SIB_RSP       = 8'h24;
    localparam logic [7:0] DISP8_ZERO    = 8'h00;
    localparam logic [7:0] OP_GRP5       = 8'hff;
    localparam logic [7:0] MODRM_JMP     = 8'he0;
    localparam logic [7:0] MODRM_CALL    = 8'hd0;
    localparam logic [7:0] OP_RET        = 8'hc3;
    localparam logic [7:0] OP_PUSH       = 8'h50;
    localparam logic [7:0] OP_POP        = 8'h58;
    localparam logic [7:0] OP_ALU_IMM8   = 8'h83;
    localparam logic [7:0] OP_ALU_IMM32  = 8'h81;
    localparam logic [7:0] OP_ADD_RAX    = 8'h05;
    localparam logic [7:0] OP_ADC_RAX    = 8'h15;
    localparam logic [7:0] OP_SUB_RAX    = 8'h2d;
    localparam logic [2:0] EXT_ADD       = 3'd0;
    localparam logic [2:0] EXT_ADC       = 3'd2;
    localparam logic [2:0] EXT_SUB       = 3'd5;
    localparam logic [7:0] OP_JMP_REL8   = 8'heb;
    localparam logic [7:0] OP_JCC_REL8   = 8'h70;
    localparam logic [7:0] SELF_REL8     = 8'hfe;
    localparam logic [7:0] OP_JMP_REL32  = 8'he9;
    localparam logic [7:0] OP_CALL_REL32 = 8'he8;
    localparam logic [7:0] OP_JCC_REL32  = 8'h80;
    localparam logic [31:0] SELF_REL32_1 = 32'hfffffffb;
    localparam logic [31:0] SELF_REL32_2 = 32'hfffffffa;

    // descriptor sizing
    localparam int MAX_BYTES     = 10;
    localparam int LEN_W         = 4;
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [4:0]  func;
        logic [3:0]  dst_reg;
        logic [3:0]  src_reg;
        logic [63:0] immediate;
        logic [3:0]  wanted_length;
        logic [4:0]  branch_cond;
    } req_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last_byte;
        logic       bad_request;
    } rsp_t;

    // one encoded instruction, byte 0 first in memory
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
        logic                      bad;
    } desc_t;

    // register-register alu opcodes, add through or, xor for any other select
    function automatic logic [7:0] alu_opcode(input logic [2:0] sel);
        logic [7:0] op;
        case (sel)
            3'd0:    op = 8'h03;
            3'd1:    op = 8'h13;
            3'd2:    op = 8'h2b;
            3'd3:    op = 8'h85;
            3'd4:    op = 8'h3b;
            3'd5:    op = 8'h23;
            3'd6:    op = 8'h0b;
            default: op = 8'h33;
        endcase
        return op;
    endfunction

endpackage

>>> hdl/x64e_front.sv
// front end: accepts requests and encodes each into a byte descriptor
// depends on x64e_pkg
module x64e_front
    import x64e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  desc_valid,
    input  logic  desc_ready,
    output desc_t desc
);

    logic  stage_valid_reg, stage_valid_next;
    desc_t desc_reg;
    desc_t enc;

    // rex.w + opcode + modrm for register-register forms
    function automatic logic [2:0][7:0] rr3(input logic [3:0] r, input logic [3:0] m,
                                            input logic [7:0] op);
        logic [2:0][7:0] v;
        v[0] = {4'h4, 1'b1, r[3], 1'b0, m[3]};
        v[1] = op;
        v[2] = {2'b11, r[2:0], m[2:0]};
        return v;
    endfunction

    always_comb
    begin
        logic [MAX_BYTES-1:0][7:0] b;
        logic [LEN_W-1:0]          len;
        logic                      bad;
        logic                      drop;
        logic [3:0]                d;
        logic [3:0]                s;
        logic [63:0]               imm;
        logic [31:0]               sv;
        logic                      small8;
        logic [2:0]                ext;
        logic [7:0]                rax_op;

        b      = '0;
        len    = LEN_W'(1);
        bad    = 1'b0;
        drop   = 1'b0;
        d      = req.dst_reg;
        s      = req.src_reg;
        imm    = req.immediate;
        sv     = imm[31:0];
        small8 = (sv[31:7] == '0) || (sv[31:7] == '1);
        ext    = EXT_ADD;
        rax_op = OP_ADD_RAX;

        case (req.func)
            FN_MOV_RR:
            begin
                b[2:0] = rr3(d, s, OP_MOV_RM);
                len    = LEN_W'(3);
            end
            FN_MOV_IMM:
            begin
                if (req.wanted_length == LEN_SHORTEST && imm == '0)
                begin
                    if (!d[3])
                    begin
                        b[0] = OP_XOR_RM;
                        b[1] = {2'b11, d[2:0], d[2:0]};
                        len  = LEN_W'(2);
                    end
                    else
                    begin
                        b[2:0] = rr3(d, d, OP_XOR_RM);
                        len    = LEN_W'(3);
                    end
                end
                else if (req.wanted_length == LEN_SHORTEST && imm[63:32] == '0)
                begin
                    // mov r32, imm32 with optional rex.b
                    b[0]   = REX_B;
                    b[1]   = OP_MOV_IMM | {5'b0, d[2:0]};
                    b[5:2] = imm[31:0];
                    len    = LEN_W'(6);
                    drop   = !d[3];
                end
                else if ((req.wanted_length == LEN_SHORTEST || req.wanted_length == LEN_SEXT32)
                         && ((imm[63:31] == '0) || (imm[63:31] == '1)))
                begin
                    b[0]   = d[3] ? REX_WB : REX_W;
                    b[1]   = OP_MOV_IMM32;
                    b[2]   = MODRM_REG | {5'b0, d[2:0]};
                    b[6:3] = imm[31:0];
                    len    = LEN_W'(7);
                end
                else
                begin
                    b[0]   = d[3] ? REX_WB : REX_W;
                    b[1]   = OP_MOV_IMM | {5'b0, d[2:0]};
                    b[9:2] = imm;
                    len    = LEN_W'(10);
                end
            end
            FN_MOVZX_MEM, FN_MOVZX_R8:
            begin
                b[0] = {4'h4, 1'b0, d[3], 1'b0, s[3]};
                b[1] = OP_ESC;
                b[2] = OP_MOVZX;
                drop = !(d[3] || s[3]);
                len  = LEN_W'(4);
                if (req.func == FN_MOVZX_R8)
                begin
                    b[3] = {2'b11, d[2:0], s[2:0]};
                end
                else
                begin
                    b[3] = {(s[2:0] == RM_RBP) ? 2'b01 : 2'b00, d[2:0], s[2:0]};
                    if (s[2:0] == RM_RSP)
                    begin
                        b[4] = SIB_RSP;
                        len  = LEN_W'(5);
                    end
                    else if (s[2:0] == RM_RBP)
                    begin
                        b[4] = DISP8_ZERO;
                        len  = LEN_W'(5);
                    end
                end
            end
            FN_JMP_R, FN_CALL_R:
            begin
                b[0] = REX_B;
                b[1] = OP_GRP5;
                b[2] = ((req.func == FN_JMP_R) ? MODRM_JMP : MODRM_CALL) | {5'b0, d[2:0]};
                len  = LEN_W'(3);
                drop = !d[3];
            end
            FN_RET:
            begin
                b[0] = OP_RET;
            end
            FN_PUSH, FN_POP:
            begin
                b[0] = REX_B;
                b[1] = ((req.func == FN_PUSH) ? OP_PUSH : OP_POP) | {5'b0, d[2:0]};
                len  = LEN_W'(2);
                drop = !d[3];
            end
            FN_ADD_RR, FN_ADC_RR, FN_SUB_RR, FN_TEST_RR, FN_CMP_RR, FN_AND_RR, FN_OR_RR:
            begin
                b[2:0] = rr3(d, s, alu_opcode(3'(req.func - FN_ADD_RR)));
                len    = LEN_W'(3);
            end
            FN_XOR_RR:
            begin
                if (d == s && !d[3])
                begin
                    b[0] = OP_XOR_RM;
                    b[1] = {2'b11, d[2:0], s[2:0]};
                    len  = LEN_W'(2);
                end
                else
                begin
                    b[2:0] = rr3(d, s, OP_XOR_RM);
                    len    = LEN_W'(3);
                end
            end
            FN_ADD_IMM, FN_ADC_IMM, FN_SUB_IMM:
            begin
                if (req.func == FN_ADC_IMM)
                begin
                    ext    = EXT_ADC;
                    rax_op = OP_ADC_RAX;
                end
                else if (req.func == FN_SUB_IMM)
                begin
                    ext    = EXT_SUB;
                    rax_op = OP_SUB_RAX;
                end
                if (small8)
                begin
                    b[2:0] = rr3({1'b0, ext}, d, OP_ALU_IMM8);
                    b[3]   = sv[7:0];
                    len    = LEN_W'(4);
                end
                else if (d == '0)
                begin
                    // short rax form
                    b[0]   = REX_W;
                    b[1]   = rax_op;
                    b[5:2] = sv;
                    len    = LEN_W'(6);
                end
                else
                begin
                    b[2:0] = rr3({1'b0, ext}, d, OP_ALU_IMM32);
                    b[6:3] = sv;
                    len    = LEN_W'(7);
                end
            end
            FN_BRANCH_S:
            begin
                len  = LEN_W'(2);
                b[1] = SELF_REL8;
                if (req.branch_cond == COND_JMP)
                    b[0] = OP_JMP_REL8;
                else if (!req.branch_cond[4])
                    b[0] = OP_JCC_REL8 | {4'b0, req.branch_cond[3:0]};
                else
                    bad = 1'b1;
            end
            FN_BRANCH_N:
            begin
                if (req.branch_cond == COND_JMP || req.branch_cond == COND_CALL)
                begin
                    b[0]   = (req.branch_cond == COND_JMP) ? OP_JMP_REL32 : OP_CALL_REL32;
                    b[4:1] = SELF_REL32_1;
                    len    = LEN_W'(5);
                end
                else if (!req.branch_cond[4])
                begin
                    b[0]   = OP_ESC;
                    b[1]   = OP_JCC_REL32 | {4'b0, req.branch_cond[3:0]};
                    b[5:2] = SELF_REL32_2;
                    len    = LEN_W'(6);
                end
                else
                    bad = 1'b1;
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase

        if (bad)
        begin
            enc.bytes = '0;
            enc.len   = LEN_W'(1);
            enc.bad   = 1'b1;
        end
        else if (drop)
        begin
            // optional prefix absent: slide the bytes down by one
            enc.bytes = b >> 8;
            enc.len   = len - LEN_W'(1);
            enc.bad   = 1'b0;
        end
        else
        begin
            enc.bytes = b;
            enc.len   = len;
            enc.bad   = 1'b0;
        end
    end

    assign req_ready  = !stage_valid_reg || desc_ready;
    assign desc_valid = stage_valid_reg;
    assign desc       = desc_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (req_valid && req_ready)
            stage_valid_next = 1'b1;
        else if (desc_ready)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            desc_reg <= enc;
    end

endmodule

>>> hdl/x64e_queue.sv
// small descriptor queue between the encoding front and the byte back end
// depends on x64e_pkg
module x64e_queue
    import x64e_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_valid,
    output logic  wr_ready,
    input  desc_t wr_data,
    output logic  rd_valid,
    input  logic  rd_ready,
    output desc_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push;
    logic           pop;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> hdl/x64e_back.sv
// back end: walks a descriptor and sends one code byte per transaction
// depends on x64e_pkg
module x64e_back
    import x64e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  desc_valid,
    output logic  desc_ready,
    input  desc_t desc,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

    desc_t            cur_reg;
    logic             cur_valid_reg, cur_valid_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             out_reg;
    logic             load;
    logic             cur_last;

    assign load       = cur_valid_reg && (!out_valid_reg || rsp_ready);
    assign cur_last   = idx_reg == (cur_reg.len - LEN_W'(1));
    // take the next descriptor when the current one is gone or leaving now
    assign desc_ready = !cur_valid_reg || (load && cur_last);

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (desc_valid && desc_ready)
        begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end
        else if (load && cur_last)
            cur_valid_next = 1'b0;
        else if (load)
            idx_next = idx_reg + LEN_W'(1);
        if (load)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_valid && desc_ready)
            cur_reg <= desc;
        if (load)
        begin
            out_reg.code_byte   <= cur_reg.bytes[idx_reg];
            out_reg.last_byte   <= cur_last;
            out_reg.bad_request <= cur_reg.bad;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

>>> hdl/x64_instruction_encoder.sv
// top level of the x86-64 instruction encoder: front, descriptor queue, back end
// depends on x64e_pkg, x64e_front, x64e_queue and x64e_back
//
// each request transaction on req becomes a run of code byte transactions on
// rsp, in memory order, the final one marked by last_byte; a request that
// cannot be encoded gives a single zero byte with bad_request and last_byte
// set. the front encodes a whole request combinationally into a registered
// descriptor of up to ten bytes, the queue holds QDEPTH descriptors, and the
// back end sends one byte per cycle from its output register while rsp_ready
// is high and descriptors wait. the first byte of a request passes the front
// register, a queue slot and the back end descriptor register, then the output
// register, before it shows on rsp; an instruction of n bytes takes n byte
// transactions on the port, so the sustained rate is one byte per cycle, set
// by the single byte-wide output port.
// requests keep being taken while bytes of earlier ones wait to leave, until
// the queue and the front register are full.
module x64_instruction_encoder
    import x64e_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    // request channel
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    // code byte channel
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // front to queue
    logic  fq_valid;
    logic  fq_ready;
    desc_t fq_data;

    // queue to back end
    logic  qb_valid;
    logic  qb_ready;
    desc_t qb_data;

    // encoder stage, one descriptor per accepted request
    x64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .desc_valid (fq_valid),
        .desc_ready (fq_ready),
        .desc       (fq_data)
    );

    // decouples encoding from byte emission
    x64e_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_data  (qb_data)
    );

    // byte sequencer with registered output
    x64e_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (qb_valid),
        .desc_ready (qb_ready),
        .desc       (qb_data),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

endmodule

>>> hdl/x64e_checker.sv
// port-level checker for the instruction encoder, bound to the top level
// depends on x64e_pkg and x64_instruction_encoder_assert.svh
`include "x64_instruction_encoder_assert.svh"

module x64e_checker
    import x64e_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    logic [3:0] open_reg, open_next;
    logic       mid_reg, mid_next;
    logic       req_fire;
    logic       end_fire;

    assign req_fire = req_valid && req_ready;
    assign end_fire = rsp_valid && rsp_ready && rsp.last_byte;

    // requests accepted whose last byte has not left yet
    always_comb
    begin
        open_next = open_reg;
        if (req_fire && !end_fire)
            open_next = open_reg + 4'd1;
        else if (end_fire && !req_fire)
            open_next = open_reg - 4'd1;
        mid_next = mid_reg;
        if (rsp_valid && rsp_ready)
            mid_next = !rsp.last_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            mid_reg  <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            mid_reg  <= mid_next;
        end
    end

    `X64E_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp), "rsp changed while stalled")
    `X64E_ASSERT_NOW(a_bad_form, clk, rst_n, rsp_valid && rsp.bad_request,
        rsp.last_byte && rsp.code_byte == 8'h00, "bad request not a single zero byte")
    `X64E_ASSERT_NOW(a_no_orphan, clk, rst_n, rsp_valid,
        open_reg != 4'd0, "code byte without an open request")
    `X64E_ASSERT_NOW(a_bad_first, clk, rst_n, rsp_valid && mid_reg,
        !rsp.bad_request, "bad flag inside an instruction")

endmodule

bind x64_instruction_encoder x64e_checker u_checker (.*);

>>> bench/x64_encoder_checker.sv
// scoreboard for the x86-64 instruction encoder: predicts and checks code bytes
// depends on x64e_pkg; watches both channels of the block without driving them
module x64_encoder_checker
    import x64e_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   fail_count,
    output int   bytes_due
);

    // register-register alu opcodes, rm-to-reg direction where the op has both forms
    localparam logic [7:0] OP_ADD_RR  = 8'h03;
    localparam logic [7:0] OP_ADC_RR  = 8'h13;
    localparam logic [7:0] OP_SUB_RR  = 8'h2b;
    localparam logic [7:0] OP_TEST_RR = 8'h85;
    localparam logic [7:0] OP_CMP_RR  = 8'h3b;
    localparam logic [7:0] OP_AND_RR  = 8'h23;
    localparam logic [7:0] OP_OR_RR   = 8'h0b;
    localparam logic [7:0] REX_BASE   = 8'h40;
    localparam logic [7:0] MOD_DISP8  = 8'h40;

    logic [7:0] insn_bytes[$];
    rsp_t       code_due[$];
    rsp_t       want;
    int         errors = 0;
    int         bytes_seen = 0;
    int         due_count = 0;

    assign fail_count = errors;
    assign bytes_due  = due_count;

    task automatic log_mismatch(input string what);
        $display("%0t: mismatch at code byte %0d: %s", $time, bytes_seen, what);
        errors++;
    endtask

    function automatic logic [7:0] rr_alu_opcode(input logic [4:0] form);
        logic [7:0] op;
        case (form)
            FN_ADD_RR:  op = OP_ADD_RR;
            FN_ADC_RR:  op = OP_ADC_RR;
            FN_SUB_RR:  op = OP_SUB_RR;
            FN_TEST_RR: op = OP_TEST_RR;
            FN_CMP_RR:  op = OP_CMP_RR;
            FN_AND_RR:  op = OP_AND_RR;
            default:    op = OP_OR_RR;
        endcase
        return op;
    endfunction

    function automatic void emit(input logic [7:0] b);
        insn_bytes = {insn_bytes, b};
    endfunction

    function automatic void emit_dword(input logic [31:0] v);
        emit(v[7:0]);
        emit(v[15:8]);
        emit(v[23:16]);
        emit(v[31:24]);
    endfunction

    // rex.w, opcode, register-direct modrm
    function automatic void emit_rr(input logic [3:0] reg_f, input logic [3:0] rm_f,
                                    input logic [7:0] opc);
        emit(REX_W | {5'b0, reg_f[3], 1'b0, rm_f[3]});
        emit(opc);
        emit(MODRM_REG | {2'b0, reg_f[2:0], rm_f[2:0]});
    endfunction

    function automatic void emit_xor(input logic [3:0] dst, input logic [3:0] src);
        if (dst == src && !dst[3])
        begin
            emit(OP_XOR_RM);
            emit(MODRM_REG | {2'b0, dst[2:0], src[2:0]});
        end
        else
            emit_rr(dst, src, OP_XOR_RM);
    endfunction

    function automatic void emit_mov_imm(input logic [3:0] dst, input logic [63:0] imm,
                                         input logic [3:0] len);
        if (len == LEN_SHORTEST && imm == 64'd0)
            emit_xor(dst, dst);
        else if (len == LEN_SHORTEST && imm <= 64'hffff_ffff)
        begin
            if (dst[3])
                emit(REX_B);
            emit(OP_MOV_IMM | {5'b0, dst[2:0]});
            emit_dword(imm[31:0]);
        end
        else if ((len == LEN_SHORTEST || len == LEN_SEXT32) &&
                 (imm < 64'h8000_0000 || imm >= 64'hffff_ffff_8000_0000))
        begin
            emit(dst[3] ? REX_WB : REX_W);
            emit(OP_MOV_IMM32);
            emit(MODRM_REG | {5'b0, dst[2:0]});
            emit_dword(imm[31:0]);
        end
        else
        begin
            emit(dst[3] ? REX_WB : REX_W);
            emit(OP_MOV_IMM | {5'b0, dst[2:0]});
            emit_dword(imm[31:0]);
            emit_dword(imm[63:32]);
        end
    endfunction

    function automatic void emit_movzx(input logic [3:0] dst, input logic [3:0] src,
                                       input bit from_mem);
        if (dst[3] || src[3])
            emit(REX_BASE | {5'b0, dst[3], 1'b0, src[3]});
        emit(OP_ESC);
        emit(OP_MOVZX);
        if (!from_mem)
            emit(MODRM_REG | {2'b0, dst[2:0], src[2:0]});
        else
        begin
            // rbp/r13 base needs disp8, rsp/r12 base needs a sib byte
            emit((src[2:0] == RM_RBP ? MOD_DISP8 : 8'h00) | {2'b0, dst[2:0], src[2:0]});
            if (src[2:0] == RM_RSP)
                emit(SIB_RSP);
            else if (src[2:0] == RM_RBP)
                emit(DISP8_ZERO);
        end
    endfunction

    function automatic void emit_alu_imm(input logic [3:0] dst, input logic [31:0] imm32,
                                         input logic [2:0] ext, input logic [7:0] rax_op);
        if (imm32 <= 32'h7f || imm32 >= 32'hffff_ff80)
        begin
            emit_rr({1'b0, ext}, dst, OP_ALU_IMM8);
            emit(imm32[7:0]);
        end
        else if (dst == 4'd0)
        begin
            emit(REX_W);
            emit(rax_op);
            emit_dword(imm32);
        end
        else
        begin
            emit_rr({1'b0, ext}, dst, OP_ALU_IMM32);
            emit_dword(imm32);
        end
    endfunction

    // fills insn_bytes; returns 1 when the request cannot be encoded
    function automatic bit encode_request(input req_t r);
        bit bad;
        bad = 1'b0;
        insn_bytes.delete();
        case (r.func)
            FN_MOV_RR:    emit_rr(r.dst_reg, r.src_reg, OP_MOV_RM);
            FN_MOV_IMM:   emit_mov_imm(r.dst_reg, r.immediate, r.wanted_length);
            FN_MOVZX_MEM: emit_movzx(r.dst_reg, r.src_reg, 1'b1);
            FN_MOVZX_R8:  emit_movzx(r.dst_reg, r.src_reg, 1'b0);
            FN_JMP_R, FN_CALL_R:
            begin
                if (r.dst_reg[3])
                    emit(REX_B);
                emit(OP_GRP5);
                emit((r.func == FN_JMP_R ? MODRM_JMP : MODRM_CALL) | {5'b0, r.dst_reg[2:0]});
            end
            FN_RET:       emit(OP_RET);
            FN_PUSH, FN_POP:
            begin
                if (r.dst_reg[3])
                    emit(REX_B);
                emit((r.func == FN_PUSH ? OP_PUSH : OP_POP) | {5'b0, r.dst_reg[2:0]});
            end
            FN_ADD_RR, FN_ADC_RR, FN_SUB_RR, FN_TEST_RR, FN_CMP_RR, FN_AND_RR, FN_OR_RR:
                emit_rr(r.dst_reg, r.src_reg, rr_alu_opcode(r.func));
            FN_XOR_RR:    emit_xor(r.dst_reg, r.src_reg);
            FN_ADD_IMM:   emit_alu_imm(r.dst_reg, r.immediate[31:0], EXT_ADD, OP_ADD_RAX);
            FN_ADC_IMM:   emit_alu_imm(r.dst_reg, r.immediate[31:0], EXT_ADC, OP_ADC_RAX);
            FN_SUB_IMM:   emit_alu_imm(r.dst_reg, r.immediate[31:0], EXT_SUB, OP_SUB_RAX);
            FN_BRANCH_S:
            begin
                if (r.branch_cond == COND_JMP)
                begin
                    emit(OP_JMP_REL8);
                    emit(SELF_REL8);
                end
                else if (r.branch_cond < COND_JMP)
                begin
                    emit(OP_JCC_REL8 | {4'b0, r.branch_cond[3:0]});
                    emit(SELF_REL8);
                end
                else
                    bad = 1'b1;
            end
            FN_BRANCH_N:
            begin
                if (r.branch_cond == COND_JMP)
                begin
                    emit(OP_JMP_REL32);
                    emit_dword(SELF_REL32_1);
                end
                else if (r.branch_cond == COND_CALL)
                begin
                    emit(OP_CALL_REL32);
                    emit_dword(SELF_REL32_1);
                end
                else if (r.branch_cond < COND_JMP)
                begin
                    emit(OP_ESC);
                    emit(OP_JCC_REL32 | {4'b0, r.branch_cond[3:0]});
                    emit_dword(SELF_REL32_2);
                end
                else
                    bad = 1'b1;
            end
            default:      bad = 1'b1;
        endcase
        return bad;
    endfunction

    function automatic void queue_code_bytes(input req_t r);
        rsp_t item;
        if (encode_request(r))
        begin
            item.code_byte   = 8'h00;
            item.last_byte   = 1'b1;
            item.bad_request = 1'b1;
            code_due = {code_due, item};
        end
        else
        begin
            foreach (insn_bytes[k])
            begin
                item.code_byte   = insn_bytes[k];
                item.last_byte   = (k == insn_bytes.size() - 1);
                item.bad_request = 1'b0;
                code_due = {code_due, item};
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                queue_code_bytes(req);
            if (rsp_valid && rsp_ready)
            begin
                if (code_due.size() == 0)
                    log_mismatch($sformatf("byte %02h arrived with nothing outstanding",
                                           rsp.code_byte));
                else
                begin
                    want = code_due.pop_front();
                    if (rsp.code_byte !== want.code_byte)
                        log_mismatch($sformatf("code_byte %02h, expected %02h",
                                               rsp.code_byte, want.code_byte));
                    if (rsp.last_byte !== want.last_byte)
                        log_mismatch($sformatf("last_byte %b, expected %b",
                                               rsp.last_byte, want.last_byte));
                    if (rsp.bad_request !== want.bad_request)
                        log_mismatch($sformatf("bad_request %b, expected %b",
                                               rsp.bad_request, want.bad_request));
                end
                bytes_seen++;
            end
        end
        due_count = code_due.size();
    end

endmodule

>>> bench/tb_x64_instruction_encoder.sv
// testbench top for the x86-64 instruction encoder: clock, reset, stimulus, verdict
// depends on x64e_pkg, x64_instruction_encoder and x64_encoder_checker
module tb_x64_instruction_encoder;
    import x64e_pkg::*;

    // cycles with no transaction on either channel before the run is abandoned
    localparam int IDLE_LIMIT   = 2000;
    // cycles to let stray bytes show up once nothing is outstanding
    localparam int DRAIN_CYCLES = 24;
    localparam int RANDOM_ITEMS = 340;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int fail_count;
    int bytes_due;
    int quiet_cycles = 0;
    // when set, neither side inserts idle cycles
    bit steady = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    x64_instruction_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // the checker sits on both channels and does all prediction and comparison
    x64_encoder_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .bytes_due  (bytes_due)
    );

    // byte receiver: stalls at random with a chance of 15 in a hundred, never while steady
    always @(negedge clk)
        rsp_ready <= steady || ($urandom_range(0, 99) >= 15);

    // watchdog: a run where nothing moves for too long is a failure
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic req_t make_request(input logic [4:0] func, input logic [3:0] dst,
                                          input logic [3:0] src, input logic [63:0] imm,
                                          input logic [3:0] len, input logic [4:0] cond);
        req_t r;
        r.func          = func;
        r.dst_reg       = dst;
        r.src_reg       = src;
        r.immediate     = imm;
        r.wanted_length = len;
        r.branch_cond   = cond;
        return r;
    endfunction

    // immediates clustered around the encoding-length decision points
    function automatic logic [63:0] pick_immediate();
        logic [63:0] v;
        logic [7:0]  lo;
        case ($urandom_range(0, 5))
            0: v = 64'd0;
            1: v = {32'd0, $urandom()};
            2: v = {32'hffff_ffff, 32'h8000_0000 | $urandom()};
            3: v = {$urandom(), $urandom()};
            4:
            begin
                case ($urandom_range(0, 9))
                    0: v = 64'h7f;
                    1: v = 64'h80;
                    2: v = 64'hffff_ff80;
                    3: v = 64'hffff_ff7f;
                    4: v = 64'h7fff_ffff;
                    5: v = 64'h8000_0000;
                    6: v = 64'hffff_ffff;
                    7: v = 64'h1_0000_0000;
                    8: v = 64'hffff_ffff_8000_0000;
                    default: v = 64'hffff_ffff_7fff_ffff;
                endcase
            end
            default:
            begin
                // signed byte in the low word, junk above it
                lo = 8'($urandom_range(0, 255));
                v  = {$urandom(), {24{lo[7]}}, lo};
            end
        endcase
        return v;
    endfunction

    function automatic req_t random_request();
        logic [4:0] func;
        logic [3:0] len;
        logic [4:0] cond;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            func = 5'($urandom_range(22, 31));
        else if (pick < 16)
            func = FN_MOV_IMM;
        else
            func = 5'($urandom_range(0, 21));
        case ($urandom_range(0, 3))
            0:       len = LEN_SHORTEST;
            1:       len = LEN_SEXT32;
            default: len = 4'($urandom_range(0, 15));
        endcase
        cond = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 17))
                                            : 5'($urandom_range(18, 31));
        return make_request(func, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                            pick_immediate(), len, cond);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input req_t item);
        while (!steady && $urandom_range(0, 99) < 15)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    initial
    begin
        int i;
        logic [4:0] f;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: a register move with an extended source register
        send_request(make_request(FN_MOV_RR, 4'd0, 4'd15, 64'd0, 4'd0, 5'd0));
        // mov imm: zero as xor (low and high register), mov r32, sign-extended, full
        send_request(make_request(FN_MOV_IMM, 4'd3, 4'd0, 64'd0, LEN_SHORTEST, 5'd0));
        send_request(make_request(FN_MOV_IMM, 4'd12, 4'd0, 64'd0, LEN_SHORTEST, 5'd0));
        send_request(make_request(FN_MOV_IMM, 4'd9, 4'd0, 64'hffff_ffff,
                                  LEN_SHORTEST, 5'd0));
        send_request(make_request(FN_MOV_IMM, 4'd2, 4'd0, 64'hffff_ffff_8000_0000,
                                  LEN_SHORTEST, 5'd0));
        send_request(make_request(FN_MOV_IMM, 4'd15, 4'd0, 64'hffff_ffff_ffff_ffff,
                                  4'd15, 5'd31));
        send_request(make_request(FN_MOV_IMM, 4'd4, 4'd0, 64'h8000_0000_0000_0000,
                                  LEN_SEXT32, 5'd0));
        // movzx from memory: sib for rsp base, disp8 for r13 base
        send_request(make_request(FN_MOVZX_MEM, 4'd1, 4'd4, 64'd0, 4'd0, 5'd0));
        send_request(make_request(FN_MOVZX_MEM, 4'd8, 4'd13, 64'd0, 4'd0, 5'd0));
        // movzx from a low byte register needs no rex
        send_request(make_request(FN_MOVZX_R8, 4'd0, 4'd0, 64'd0, 4'd0, 5'd0));
        send_request(make_request(FN_JMP_R, 4'd11, 4'd0, 64'd0, 4'd0, 5'd0));
        send_request(make_request(FN_CALL_R, 4'd3, 4'd0, 64'd0, 4'd0, 5'd0));
        send_request(make_request(FN_RET, 4'd0, 4'd0, 64'd0, 4'd0, 5'd0));
        send_request(make_request(FN_PUSH, 4'd15, 4'd0, 64'd0, 4'd0, 5'd0));
        send_request(make_request(FN_POP, 4'd0, 4'd0, 64'd0, 4'd0, 5'd0));
        // every register-register alu op; xor of a low register with itself is short
        for (f = FN_ADD_RR; f <= FN_XOR_RR; f++)
            send_request(make_request(f, f[3:0], (f == FN_XOR_RR) ? f[3:0] : ~f[3:0],
                                      64'd0, 4'd0, 5'd0));
        // alu immediates: imm8 edge, short rax form, negative imm8 edge with upper bits set
        send_request(make_request(FN_ADD_IMM, 4'd0, 4'd0, 64'h7f, 4'd0, 5'd0));
        send_request(make_request(FN_ADC_IMM, 4'd0, 4'd0, 64'h80, 4'd0, 5'd0));
        send_request(make_request(FN_SUB_IMM, 4'd12, 4'd0, 64'h5a5a_5a5a_ffff_ff80,
                                  4'd0, 5'd0));
        // branches: short call is invalid, a condition code, near call, bad cond, bad form
        send_request(make_request(FN_BRANCH_S, 4'd0, 4'd0, 64'd0, 4'd0, COND_CALL));
        send_request(make_request(FN_BRANCH_S, 4'd0, 4'd0, 64'd0, 4'd0, 5'd15));
        send_request(make_request(FN_BRANCH_N, 4'd0, 4'd0, 64'd0, 4'd0, COND_CALL));
        send_request(make_request(FN_BRANCH_N, 4'd0, 4'd0, 64'd0, 4'd0, 5'd31));
        send_request(make_request(5'd31, 4'd15, 4'd15, 64'd0, 4'd0, 5'd0));

        // random part, with a stretch where neither side idles
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            steady = (i >= 120 && i < 200);
            send_request(random_request());
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        // let every predicted byte arrive, then watch a while for extra ones
        while (bytes_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/x64e_pkg.sv
hdl/x64e_front.sv
hdl/x64e_queue.sv
hdl/x64e_back.sv
hdl/x64_instruction_encoder.sv
hdl/x64e_checker.sv
bench/x64_encoder_checker.sv
bench/tb_x64_instruction_encoder.sv
